// ===== design/stereo_chorus_delay_line_macros.svh =====
// assertion helpers for the chorus block
`ifndef STEREO_CHORUS_DELAY_LINE_MACROS_SVH
`define STEREO_CHORUS_DELAY_LINE_MACROS_SVH

`define SCD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SCD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/scd_pkg.sv =====
package scd_pkg;

    localparam int LINE_DEPTH_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SINE_ENTRIES    = 256;
    localparam int SINE_IDX_W      = 8;

    localparam logic [2:0] REG_WAVE = 3'd0;
    localparam logic [2:0] REG_INC  = 3'd1;
    localparam logic [2:0] REG_OFS  = 3'd2;
    localparam logic [2:0] REG_BASE = 3'd3;
    localparam logic [2:0] REG_DEPT = 3'd4;
    localparam logic [2:0] REG_FB   = 3'd5;

    typedef struct packed {
        logic        wave;
        logic [31:0] inc;
        logic [31:0] ofs;
        logic [10:0] base;
        logic [15:0] depth;
        logic [15:0] fb;
    } t_cfg;

    // quarter sine in q14, entries 0..256
    function automatic logic [14:0] sine_q(input logic [8:0] k);
        logic [63:0] x;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        begin
            x = (64'd1686629713 * 64'(k)) / 64'(SINE_ENTRIES);
            term = x;
            sum = $signed(x);
            for (int n = 1; n <= 6; n++) begin
                term = (term * x) >> 30;
                term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - $signed(term);
                else sum = sum + $signed(term);
            end
            v = (sum > 0) ? ((sum + 64'sd32768) >>> 16) : 64'sd0;
            if (v > 64'sd16384) v = 64'sd16384;
            sine_q = v[14:0];
        end
    endfunction

endpackage

// ===== design/stereo_chorus_delay_line.sv =====
// an accepted input steps through LFO, MUL, ADR_L, ADR_R, RD_L, WR_L and DONE
// before its output beat is valid; a new input is taken only in IDLE, as the sequencer
// runs the tap multiplies and one read-then-write of each delay memory per item
// the next input is taken while a finished output waits; it then holds in its last step
// reset clears config, pointers and control; a sweep then zeroes all LINE_DEPTH entries
module stereo_chorus_delay_line import scd_pkg::*; #(
    parameter int LINE_DEPTH  = LINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // sample_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // wet_left, wet_right
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_LFO = 4'd2, ST_MUL = 4'd3;
    localparam logic [3:0] ST_ADR_L = 4'd4, ST_ADR_R = 4'd5, ST_RD_L = 4'd6;
    localparam logic [3:0] ST_WR_L = 4'd7, ST_DONE = 4'd8;

    t_cfg r_cfg;
    logic [3:0] r_st;
    logic [AW-1:0] r_wp, r_clr, tap, r_ra, addr_l, addr_r;
    logic [31:0] r_ph;
    logic [15:0] r_x;
    logic [15:0] r_wl, r_wr, rd_l, rd_r;
    logic [15:0] r_out_l, r_out_r;
    logic r_ov;
    logic [15:0] w_l, w_r;
    logic we_l, we_r;
    logic [2:0] ridx;
    logic fin;

    function automatic logic [15:0] feed(input logic [15:0] wet, input logic [15:0] xin,
                                         input logic [15:0] g);
        logic signed [16:0] sm;
        logic signed [32:0] p;
        logic signed [17:0] r;
        begin
            sm = $signed({wet[15], wet}) + $signed({xin[15], xin});
            p = sm * $signed(g);
            r = (p >>> 15) > 33'sd65535 ? 18'sd65535 :
                ((p >>> 15) < -33'sd65536 ? -18'sd65536 : 18'(p >>> 15));
            if (r > 18'sd32767) feed = 16'h7fff;
            else if (r < -18'sd32768) feed = 16'h8000;
            else feed = r[15:0];
        end
    endfunction

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    always_comb begin
        case (ridx)
            REG_WAVE: prdata = {31'd0, r_cfg.wave};
            REG_INC:  prdata = r_cfg.inc;
            REG_OFS:  prdata = r_cfg.ofs;
            REG_BASE: prdata = {21'd0, r_cfg.base};
            REG_DEPT: prdata = {16'd0, r_cfg.depth};
            REG_FB:   prdata = {16'd0, r_cfg.fb};
            default:  prdata = 32'd0;
        endcase
    end

    // left phase while idle, right phase from the first busy cycle on
    scd_tap #(.LINE_DEPTH(LINE_DEPTH)) u_tap (
        .i_clk(i_clk), .i_cfg(r_cfg),
        .i_phase(r_st == ST_IDLE ? r_ph : r_ph + r_cfg.ofs), .o_tap(tap)
    );

    assign w_l = feed(r_wl, r_x, r_cfg.fb);
    assign w_r = feed(r_wr, r_x, r_cfg.fb);
    assign we_l = (r_st == ST_CLR) || (r_st == ST_WR_L);
    assign we_r = (r_st == ST_CLR) || (r_st == ST_DONE);
    assign addr_l = r_st == ST_CLR ? r_clr : (r_st == ST_WR_L ? r_wp : r_ra);
    assign addr_r = r_st == ST_CLR ? r_clr : (r_st == ST_DONE ? r_wp : r_ra);

    scd_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_left (
        .i_clk(i_clk), .i_we(we_l), .i_addr(addr_l),
        .i_wdata(r_st == ST_CLR ? 16'd0 : w_l), .o_rdata(rd_l));
    scd_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_right (
        .i_clk(i_clk), .i_we(we_r), .i_addr(addr_r),
        .i_wdata(r_st == ST_CLR ? 16'd0 : w_r), .o_rdata(rd_r));

    // last step completes once the output register is free
    assign fin = (r_st == ST_DONE) && (!r_ov || i_m_axis_tready);

    assign o_s_axis_tready = (r_st == ST_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata = {r_out_r, r_out_l};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_st <= ST_CLR;
            r_clr <= '0;
            r_wp <= '0;
            r_ph <= '0;
            r_ov <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                case (ridx)
                    REG_WAVE: r_cfg.wave <= pwdata[0];
                    REG_INC:  r_cfg.inc <= pwdata;
                    REG_OFS:  r_cfg.ofs <= pwdata;
                    REG_BASE: r_cfg.base <= pwdata[10:0];
                    REG_DEPT: r_cfg.depth <= pwdata[15:0];
                    REG_FB:   r_cfg.fb <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (fin) r_ov <= 1'b1;
            else if (r_ov && i_m_axis_tready) r_ov <= 1'b0;
            case (r_st)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_st <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_s_axis_tvalid && o_s_axis_tready) begin
                        r_x <= i_s_axis_tdata;
                        r_st <= ST_LFO;
                    end
                end
                ST_LFO: r_st <= ST_MUL;
                ST_MUL: r_st <= ST_ADR_L;
                ST_ADR_L: begin r_ra <= r_wp - tap; r_st <= ST_ADR_R; end
                ST_ADR_R: begin r_ra <= r_wp - tap; r_st <= ST_RD_L; end
                ST_RD_L: begin r_wl <= rd_l; r_st <= ST_WR_L; end
                ST_WR_L: begin r_wr <= rd_r; r_st <= ST_DONE; end
                ST_DONE: begin
                    if (fin) begin
                        r_out_l <= r_wl;
                        r_out_r <= r_wr;
                        r_wp <= r_wp + 1'b1;
                        r_ph <= r_ph + r_cfg.inc;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== design/scd_ram.sv =====
module scd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/scd_tap.sv =====
module scd_tap import scd_pkg::*; #(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  t_cfg                          i_cfg,
    input  logic [31:0]                   i_phase,
    output logic [$clog2(LINE_DEPTH)-1:0] o_tap
);
    localparam int AW = $clog2(LINE_DEPTH);

    logic [15:0] lfo;
    logic [16:0] tri_d;
    logic [15:0] x;
    logic [8:0]  si;
    logic [8:0]  sk;
    logic [14:0] s;
    logic [15:0] r_lfo;
    logic [31:0] r_prod;
    logic [42:0] prod2;
    logic [14:0] add;
    logic [15:0] t;
    logic [14:0] sine_tab [SINE_ENTRIES + 1];

    // constant quarter sine table
    for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_sine
        assign sine_tab[k] = sine_q(9'(k));
    end

    always_comb begin
        x = i_phase[31:16];
        tri_d = 17'd32768 - {1'b0, x};
        if (tri_d[16]) tri_d = -tri_d;
        si = {1'b0, i_phase[29:22]};
        sk = i_phase[30] ? (9'd256 - si) : si;
        s = sine_tab[sk];
        if (!i_cfg.wave) lfo = 16'(17'd32768 - tri_d);
        else if (i_phase[31]) lfo = 16'(16'd16384 - {1'b0, s});
        else lfo = 16'(16'd16384 + {1'b0, s});
    end

    always_ff @(posedge i_clk) begin
        r_lfo  <= lfo;
        r_prod <= r_lfo * i_cfg.depth;
        o_tap  <= t >= 16'(LINE_DEPTH - 1) ? AW'(LINE_DEPTH - 1) : t[AW-1:0];
    end

    always_comb begin
        prod2 = r_prod * i_cfg.base;
        add = prod2[43-1:29] > 14'h3fff ? 15'h7fff : {1'b0, prod2[42:29]};
        t = 16'(add) + 16'(i_cfg.base);
    end
endmodule

// ===== design/scd_checker.sv =====
`include "stereo_chorus_delay_line_macros.svh"
module scd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tvalid,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        pready
);
    `SCD_ASSERT(a_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata),
        "output beat dropped")
    `SCD_ASSERT(a_busy, i_clk, i_rst_n,
        o_s_axis_tready && i_s_axis_tvalid |=> !o_s_axis_tready,
        "input taken while busy")
    `SCD_ASSERT(a_noout, i_clk, i_rst_n,
        o_s_axis_tready && i_s_axis_tvalid |=> !$rose(o_m_axis_tvalid),
        "output too early")
    `SCD_ASSERT_NR(a_pready, i_clk, pready, "pready low")
endmodule

bind stereo_chorus_delay_line scd_checker u_scd_checker (.*);

// ===== tb/sv/tb_stereo_chorus_delay_line.sv =====
module tb_stereo_chorus_delay_line;
    import scd_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int MAX_CYC   = 900000;
    localparam int SETTLE    = 16;
    localparam logic [2:0] REG_NONE_A = 3'd6;
    localparam logic [2:0] REG_NONE_B = 3'd7;

    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
    } t_wet_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data = '0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;
    logic [31:0] prdata;
    logic        pready;

    stereo_chorus_delay_line uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),     // sample_in
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data),     // wet_left, wet_right
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    // chorus state as the block should hold it
    logic                cfg_wave;
    logic [31:0]         cfg_inc, cfg_ofs;
    logic [10:0]         cfg_base;
    logic [15:0]         cfg_depth;
    logic signed [15:0]  cfg_fb;
    logic signed [15:0]  left_mem [DEPTH];
    logic signed [15:0]  right_mem [DEPTH];
    logic [11:0]         wr_pos;
    logic [31:0]         phase_acc;
    int                  quarter_sine [SINE_ENTRIES + 1];

    logic [15:0] samples_to_send [$];
    t_wet_pair   wet_expected [$];
    int  errors = 0;
    int  n_in = 0, n_out = 0, cycles = 0;
    int  tx_idle = 0, rx_idle = 0, rx_hold = 0;
    int  cur_phase = -1;
    bit  hold_done = 1'b0;
    bit  tx_pause = 1'b0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s at output %0d: got %0d expected %0d", what, n_out, got, want);
        errors++;
    endtask

    function automatic void fill_sine();
        longint unsigned ang, term;
        longint signed acc, rnd;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            ang = (64'd1686629713 * longint'(k)) / SINE_ENTRIES;
            term = ang;
            acc = ang;
            for (int n = 1; n <= 6; n++) begin
                term = (term * ang) >> 30;
                term = ((term * ang) >> 30) / longint'((2 * n) * (2 * n + 1));
                acc = (n % 2) ? acc - longint'(term) : acc + longint'(term);
            end
            rnd = (acc > 0) ? ((acc + 32768) >>> 16) : 0;
            quarter_sine[k] = (rnd > 16384) ? 16384 : int'(rnd);
        end
    endfunction

    function automatic longint lfo_level(input logic [31:0] p);
        int x, d, idx, s;
        if (!cfg_wave) begin
            x = p[31:16];
            d = 32768 - x;
            if (d < 0) d = -d;
            return 32768 - d;
        end
        idx = p[29:22];
        s = p[30] ? quarter_sine[SINE_ENTRIES - idx] : quarter_sine[idx];
        if (p[31]) s = -s;
        return 16384 + s;
    endfunction

    function automatic int tap_for(input logic [31:0] p);
        longint t;
        t = cfg_base + ((lfo_level(p) * cfg_depth * cfg_base) >>> 29);
        return (t > DEPTH - 1) ? DEPTH - 1 : int'(t);
    endfunction

    function automatic logic signed [15:0] feedback_of(input longint wet, input longint x);
        longint prod;
        prod = ((wet + x) * cfg_fb) >>> 15;
        if (prod > 32767) prod = 32767;
        if (prod < -32768) prod = -32768;
        return prod[15:0];
    endfunction

    function automatic t_wet_pair chorus_step(input logic signed [15:0] x);
        t_wet_pair r;
        logic [11:0] rd;
        rd = wr_pos - 12'(tap_for(phase_acc));
        r.left = left_mem[rd];
        left_mem[wr_pos] = feedback_of(r.left, x);
        rd = wr_pos - 12'(tap_for(phase_acc + cfg_ofs));
        r.right = right_mem[rd];
        right_mem[wr_pos] = feedback_of(r.right, x);
        wr_pos = wr_pos + 1'b1;
        phase_acc = phase_acc + cfg_inc;
        return r;
    endfunction

    // sender: takes samples from the pending queue, predicts on each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                wet_expected.push_back(chorus_step(s_data));
                n_in++;
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (!tx_pause && samples_to_send.size() > 0 &&
                         $urandom_range(0, 99) >= tx_idle) begin
                s_valid <= 1'b1;
                s_data <= samples_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (cur_phase == 6 && !hold_done) begin
            hold_done <= 1'b1;
            rx_hold <= 300;
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        t_wet_pair want;
        if (i_rst_n && m_valid && m_ready) begin
            if (wet_expected.size() == 0) begin
                report("unexpected beat", m_data, 0);
            end else begin
                want = wet_expected.pop_front();
                if ($signed(m_data[15:0]) != want.left)
                    report("wet_left", $signed(m_data[15:0]), want.left);
                if ($signed(m_data[31:16]) != want.right)
                    report("wet_right", $signed(m_data[31:16]), want.right);
            end
            n_out++;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("timeout with %0d results outstanding", wet_expected.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WAVE: cfg_wave = val[0];
            REG_INC:  cfg_inc = val;
            REG_OFS:  cfg_ofs = val;
            REG_BASE: cfg_base = val[10:0];
            REG_DEPT: cfg_depth = val[15:0];
            REG_FB:   cfg_fb = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic w, input logic [31:0] inc, input logic [31:0] ofs,
                           input logic [10:0] base, input logic [15:0] dep,
                           input logic [15:0] fb);
        reg_write(REG_WAVE, {31'd0, w});
        reg_write(REG_INC, inc);
        reg_write(REG_OFS, ofs);
        reg_write(REG_BASE, {21'd0, base});
        reg_write(REG_DEPT, {16'd0, dep});
        reg_write(REG_FB, {16'd0, fb});
    endtask

    // checked between edges so that queue and valid updates have settled
    task automatic drain();
        while (samples_to_send.size() > 0 || s_valid || wet_expected.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [10:0] b;
        logic [15:0] extremes [7];
        fill_sine();
        cfg_wave = 0; cfg_inc = 0; cfg_ofs = 0; cfg_base = 0; cfg_depth = 0; cfg_fb = 0;
        for (int i = 0; i < DEPTH; i++) begin
            left_mem[i] = 0;
            right_mem[i] = 0;
        end
        wr_pos = 0;
        phase_acc = 0;
        extremes = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults, field extremes
        foreach (extremes[i])
            samples_to_send.push_back(extremes[i]);
        drain();
        // zero tap reads the old entry; strongest negative gain saturates
        set_all(1'b0, 32'd0, 32'd0, 11'd0, 16'd0, 16'h8000);
        reg_write(REG_NONE_A, 32'hffff_ffff);
        reg_write(REG_NONE_B, 32'h1234_5678);
        repeat (6) samples_to_send.push_back(16'h8000);
        drain();
        // long tap clamp with depth above one, sine and triangle
        set_all(1'b1, 32'h4000_0000, 32'h8000_0000, 11'd1365, 16'hffff, 16'h7fff);
        repeat (4) samples_to_send.push_back(16'h7fff);
        drain();
        set_all(1'b0, 32'hffff_ffff, 32'hffff_ffff, 11'd1365, 16'd32768, 16'h7fff);
        repeat (4) samples_to_send.push_back(16'h8001);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            tx_idle = (ph < 3) ? 23 : (ph < 6) ? 80 : 0;
            rx_idle = (ph < 3) ? 80 : (ph < 6) ? 23 : 0;
            b = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 1365))
                                            : 11'($urandom_range(0, 40));
            if (ph == 8) b = 11'd1365;
            set_all(ph[0], (ph == 2) ? 32'hffff_ffff : $urandom >> $urandom_range(0, 31),
                    $urandom, b, (ph == 4) ? 16'hffff : 16'($urandom_range(0, 32768)),
                    (ph == 5) ? 16'h8000 : 16'($urandom));
            for (int k = 0; k < 120; k++) samples_to_send.push_back(16'($urandom));
            // phase 6: receiver holds off long enough that the input side stalls
            cur_phase = ph;
            if (ph == 3) begin
                // sender pauses until every expected result has come back
                repeat (200) @(posedge i_clk);
                tx_pause = 1'b1;
                while (s_valid || wet_expected.size() > 0) @(negedge i_clk);
                tx_pause = 1'b0;
            end
            drain();
        end

        $display("covered %0d samples in, %0d wet pairs out, over both lfo shapes", n_in, n_out);
        $display("and settings from zero tap to clamped long taps with full feedback range");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/scd_pkg.sv
design/scd_ram.sv
design/scd_tap.sv
design/stereo_chorus_delay_line.sv
design/scd_checker.sv
tb/sv/tb_stereo_chorus_delay_line.sv
